// ===== design/wss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_pkg
// Shared sizes, request codes and the table command bundle of the weighted
// source selector.
// ----------------------------------------------------------------------------
package wss_pkg;

   // table and field sizes
   localparam int MAX_SOURCES = 16;
   localparam int IDX_BITS    = $clog2(MAX_SOURCES);
   localparam int CNT_BITS    = IDX_BITS + 1;
   localparam int WEIGHT_BITS = 16;
   localparam int FRAC_BITS   = 24;
   localparam int CUM_BITS    = WEIGHT_BITS + IDX_BITS;
   localparam int PROD_BITS   = FRAC_BITS + CUM_BITS;

   // stream packing
   localparam int REQ_USER_BITS  = 2;
   localparam int REQ_FIELD_BITS = IDX_BITS + WEIGHT_BITS + FRAC_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = IDX_BITS + 3;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // bit positions inside the stream words
   localparam int REQ_WEIGHT_LSB = IDX_BITS;
   localparam int REQ_FRAC_LSB   = IDX_BITS + WEIGHT_BITS;
   localparam int REQ_KIND_BIT   = IDX_BITS + WEIGHT_BITS + FRAC_BITS;
   localparam int RSP_VALID_BIT  = IDX_BITS;
   localparam int RSP_DONE_BIT   = IDX_BITS + 1;
   localparam int RSP_ERROR_BIT  = IDX_BITS + 2;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = CNT_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_SOURCES = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_MODE = CSR_INDEX_BITS'(1);

   localparam logic [IDX_BITS-1:0] LAST_SOURCE = IDX_BITS'(MAX_SOURCES - 1);

   // request kinds carried in tuser
   typedef enum logic [REQ_USER_BITS-1:0] {
      REQ_LOAD    = 2'd0,
      REQ_DRAW    = 2'd1,
      REQ_END     = 2'd2,
      REQ_RESTART = 2'd3
   } req_kind_type;

   // access bundle for the weight tables
   typedef struct packed {
      logic                   base_we;
      logic [IDX_BITS-1:0]    base_waddr;
      logic [WEIGHT_BITS-1:0] base_wdata;
      logic [IDX_BITS-1:0]    base_raddr;
      logic                   cum_we;
      logic [IDX_BITS-1:0]    cum_waddr;
      logic [CUM_BITS-1:0]    cum_wdata;
      logic [IDX_BITS-1:0]    cum_raddr;
   } mem_cmd_type;

   // source count in use: zero acts as one, large values clamp to the table
   function automatic logic [CNT_BITS-1:0] active_count(input logic [CNT_BITS-1:0] raw);
      logic [CNT_BITS-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = CNT_BITS'(1);
      end else if (raw > CNT_BITS'(MAX_SOURCES)) begin
         n = CNT_BITS'(MAX_SOURCES);
      end
      return n;
   endfunction

endpackage

// ===== design/weighted_source_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_source_selector
// Weighted random choice of a source through a cumulative weight table with
// a binary search, done tracking and weight removal of drained sources.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tuser kind, tdata index/weight/fraction/end kind
//  rsp      out        rsp_tvalid/tready     tdata choice and status
//  csr      in         csr_valid/ready       register index and data
//
//  After reset a clearing pass over all 16 entries zeroes both tables; no
//  request is taken then. One request is worked at a time, set by the single
//  table read port: a load, or a drained-source report with repeats off, walks
//  the prefix sums upward from its entry; a restart rebuilds all 16 sums from
//  the base weights; a draw forms the product, runs up to four search probes
//  and skips forward over done sources. A stalled response holds the output
//  register while the next request is already taken.
// ----------------------------------------------------------------------------
module weighted_source_selector (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [1:0] req_type
   input  logic [wss_pkg::REQ_USER_BITS-1:0]    req_tuser,
   // [3:0] source_index, [19:4] weight_value, [43:20] random_fraction,
   // [44] end_kind, [47:45] zero
   input  logic [wss_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [3:0] chosen_source, [4] choice_valid, [5] all_sources_done,
   // [6] request_error, [7] zero
   output logic [wss_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wss_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import wss_pkg::*;

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_U_PREV  = 11'b000_0000_0100,
      ST_U_DELTA = 11'b000_0000_1000,
      ST_U_WALK  = 11'b000_0001_0000,
      ST_REBUILD = 11'b000_0010_0000,
      ST_D_TOTAL = 11'b000_0100_0000,
      ST_D_ISSUE = 11'b000_1000_0000,
      ST_D_CMP   = 11'b001_0000_0000,
      ST_D_SKIP  = 11'b010_0000_0000,
      ST_RESP    = 11'b100_0000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_BITS-1:0]      ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]      idx_ff, idx_in;
   logic [WEIGHT_BITS-1:0]   weight_ff, weight_in;
   logic [FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [CUM_BITS-1:0]      prev_ff, prev_in;
   logic [CUM_BITS-1:0]      delta_ff, delta_in;
   logic [CUM_BITS-1:0]      sum_ff, sum_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [IDX_BITS-1:0]      lo_ff, lo_in;
   logic [IDX_BITS-1:0]      hi_ff, hi_in;
   logic [IDX_BITS-1:0]      mid_ff, mid_in;
   logic [IDX_BITS-1:0]      res_chosen_ff, res_chosen_in;
   logic                     res_valid_ff, res_valid_in;
   logic                     res_err_ff, res_err_in;
   logic [MAX_SOURCES-1:0]   done_ff, done_in;
   logic [CNT_BITS-1:0]      num_sources_ff, num_sources_in;
   logic                     repeat_mode_ff, repeat_mode_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   mem_cmd_type              mem_cmd;
   logic [WEIGHT_BITS-1:0]   base_rdata;
   logic [CUM_BITS-1:0]      cum_rdata;

   logic [CNT_BITS-1:0]      n_active;
   logic [IDX_BITS-1:0]      n_last;
   logic [MAX_SOURCES-1:0]   active_mask;
   logic                     all_done;
   logic                     req_take;
   req_kind_type             in_kind;
   logic [IDX_BITS-1:0]      in_idx;
   logic [WEIGHT_BITS-1:0]   in_weight;
   logic [FRAC_BITS-1:0]     in_frac;
   logic                     in_end_kind;
   logic                     idx_bad;
   logic [CUM_BITS-1:0]      new_cum;
   logic [CNT_BITS-1:0]      mid_sum;
   logic [CNT_BITS-1:0]      lo_next;

   // weight tables
   wss_store u_store (
      .clock      (clock),
      .cmd        (mem_cmd),
      .base_rdata (base_rdata),
      .cum_rdata  (cum_rdata)
   );

   // sources in use and the all-done test
   assign n_active = active_count(num_sources_ff);
   assign n_last   = IDX_BITS'(n_active - CNT_BITS'(1));
   always_comb begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
         active_mask[i] = (CNT_BITS'(i) < n_active);
      end
   end
   assign all_done = &(done_ff | ~active_mask);

   // request fields
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_take    = req_tvalid && req_tready;
   assign in_kind     = req_kind_type'(req_tuser);
   assign in_idx      = req_tdata[IDX_BITS-1:0];
   assign in_weight   = req_tdata[REQ_WEIGHT_LSB +: WEIGHT_BITS];
   assign in_frac     = req_tdata[REQ_FRAC_LSB +: FRAC_BITS];
   assign in_end_kind = req_tdata[REQ_KIND_BIT];
   assign idx_bad     = ({1'b0, in_idx} >= n_active);

   // datapath helpers
   assign new_cum = prev_ff + CUM_BITS'(weight_ff);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign lo_next = {1'b0, lo_ff} + CNT_BITS'(1);

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      num_sources_in = num_sources_ff;
      repeat_mode_in = repeat_mode_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_SOURCES) begin
            num_sources_in = csr_data;
         end else if (csr_index == CSR_REPEAT_MODE) begin
            repeat_mode_in = csr_data[0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      weight_in     = weight_ff;
      frac_in       = frac_ff;
      prev_in       = prev_ff;
      delta_in      = delta_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_chosen_in = res_chosen_ff;
      res_valid_in  = res_valid_ff;
      res_err_in    = res_err_ff;
      done_in       = done_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_cmd       = '0;

      unique case (state_ff)
         // zero both tables after reset
         ST_CLEAR: begin
            mem_cmd.base_we    = 1'b1;
            mem_cmd.base_waddr = ptr_ff;
            mem_cmd.cum_we     = 1'b1;
            mem_cmd.cum_waddr  = ptr_ff;
            if (ptr_ff == LAST_SOURCE) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + IDX_BITS'(1);
            end
         end

         // take a request and start its work
         ST_IDLE: begin
            if (req_take) begin
               idx_in        = in_idx;
               weight_in     = in_weight;
               frac_in       = in_frac;
               res_chosen_in = '0;
               res_valid_in  = 1'b0;
               res_err_in    = 1'b0;
               unique case (in_kind)
                  REQ_LOAD: begin
                     if (idx_bad) begin
                        res_err_in = 1'b1;
                        state_in   = ST_RESP;
                     end else begin
                        mem_cmd.base_we    = 1'b1;
                        mem_cmd.base_waddr = in_idx;
                        mem_cmd.base_wdata = in_weight;
                        mem_cmd.cum_raddr  = in_idx - IDX_BITS'(1);
                        state_in           = ST_U_PREV;
                     end
                  end
                  REQ_END: begin
                     if (idx_bad) begin
                        res_err_in = 1'b1;
                        state_in   = ST_RESP;
                     end else begin
                        done_in[in_idx] = 1'b1;
                        if (!in_end_kind && !repeat_mode_ff) begin
                           weight_in         = '0;
                           mem_cmd.cum_raddr = in_idx - IDX_BITS'(1);
                           state_in          = ST_U_PREV;
                        end else begin
                           state_in = ST_RESP;
                        end
                     end
                  end
                  REQ_DRAW: begin
                     if (all_done) begin
                        state_in = ST_RESP;
                     end else begin
                        mem_cmd.cum_raddr = n_last;
                        state_in          = ST_D_TOTAL;
                     end
                  end
                  REQ_RESTART: begin
                     done_in            = '0;
                     ptr_in             = '0;
                     sum_in             = '0;
                     mem_cmd.base_raddr = '0;
                     state_in           = ST_REBUILD;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // prefix sum just below the entry
         ST_U_PREV: begin
            prev_in           = (idx_ff == '0) ? '0 : cum_rdata;
            mem_cmd.cum_raddr = idx_ff;
            state_in          = ST_U_DELTA;
         end

         // rewrite the entry and find the shift for the entries above it
         ST_U_DELTA: begin
            mem_cmd.cum_we    = 1'b1;
            mem_cmd.cum_waddr = idx_ff;
            mem_cmd.cum_wdata = new_cum;
            delta_in          = new_cum - cum_rdata;
            if (idx_ff == LAST_SOURCE) begin
               state_in = ST_RESP;
            end else begin
               ptr_in            = idx_ff + IDX_BITS'(1);
               mem_cmd.cum_raddr = idx_ff + IDX_BITS'(1);
               state_in          = ST_U_WALK;
            end
         end

         // shift the upper prefix sums, one entry a cycle
         ST_U_WALK: begin
            mem_cmd.cum_we    = 1'b1;
            mem_cmd.cum_waddr = ptr_ff;
            mem_cmd.cum_wdata = cum_rdata + delta_ff;
            if (ptr_ff == LAST_SOURCE) begin
               state_in = ST_RESP;
            end else begin
               ptr_in            = ptr_ff + IDX_BITS'(1);
               mem_cmd.cum_raddr = ptr_ff + IDX_BITS'(1);
            end
         end

         // rebuild prefix sums from the base weights
         ST_REBUILD: begin
            mem_cmd.cum_we    = 1'b1;
            mem_cmd.cum_waddr = ptr_ff;
            mem_cmd.cum_wdata = sum_ff + CUM_BITS'(base_rdata);
            sum_in            = sum_ff + CUM_BITS'(base_rdata);
            if (ptr_ff == LAST_SOURCE) begin
               state_in = ST_RESP;
            end else begin
               ptr_in             = ptr_ff + IDX_BITS'(1);
               mem_cmd.base_raddr = ptr_ff + IDX_BITS'(1);
            end
         end

         // scale the fraction by the total weight
         ST_D_TOTAL: begin
            if (cum_rdata == '0) begin
               res_err_in = 1'b1;
               state_in   = ST_RESP;
            end else begin
               prod_in  = PROD_BITS'(frac_ff) * PROD_BITS'(cum_rdata);
               lo_in    = '0;
               hi_in    = n_last;
               state_in = ST_D_ISSUE;
            end
         end

         // next search probe
         ST_D_ISSUE: begin
            if (lo_ff == hi_ff) begin
               state_in = ST_D_SKIP;
            end else begin
               mid_in            = mid_sum[IDX_BITS:1];
               mem_cmd.cum_raddr = mid_sum[IDX_BITS:1];
               state_in          = ST_D_CMP;
            end
         end

         // first entry whose scaled sum passes the target
         ST_D_CMP: begin
            if ({cum_rdata, {FRAC_BITS{1'b0}}} > prod_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + IDX_BITS'(1);
            end
            state_in = ST_D_ISSUE;
         end

         // step past done sources, wrapping at the last one in use
         ST_D_SKIP: begin
            if (!repeat_mode_ff && done_ff[lo_ff]) begin
               lo_in = (lo_next < n_active) ? lo_next[IDX_BITS-1:0] : '0;
            end else begin
               res_chosen_in = lo_ff;
               res_valid_in  = 1'b1;
               state_in      = ST_RESP;
            end
         end

         // hand the result to the output register
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_BITS'({res_err_ff, all_done, res_valid_ff,
                                              res_chosen_ff});
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         ptr_ff         <= '0;
         done_ff        <= '0;
         num_sources_ff <= CNT_BITS'(1);
         repeat_mode_ff <= 1'b1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ptr_ff         <= ptr_in;
         done_ff        <= done_in;
         num_sources_ff <= num_sources_in;
         repeat_mode_ff <= repeat_mode_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      weight_ff     <= weight_in;
      frac_ff       <= frac_in;
      prev_ff       <= prev_in;
      delta_ff      <= delta_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_chosen_ff <= res_chosen_in;
      res_valid_ff  <= res_valid_in;
      res_err_ff    <= res_err_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== design/wss_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_store
// Base weight table and cumulative weight table, each a one-write one-read
// synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module wss_store (
   input  logic                            clock,
   input  wss_pkg::mem_cmd_type            cmd,
   output logic [wss_pkg::WEIGHT_BITS-1:0] base_rdata,
   output logic [wss_pkg::CUM_BITS-1:0]    cum_rdata
);
   import wss_pkg::*;

   logic [WEIGHT_BITS-1:0] base_mem_ff [MAX_SOURCES];
   logic [CUM_BITS-1:0]    cum_mem_ff  [MAX_SOURCES];
   logic [WEIGHT_BITS-1:0] base_rd_ff;
   logic [CUM_BITS-1:0]    cum_rd_ff;

   // base weights
   always_ff @(posedge clock) begin
      if (cmd.base_we) begin
         base_mem_ff[cmd.base_waddr] <= cmd.base_wdata;
      end
      base_rd_ff <= base_mem_ff[cmd.base_raddr];
   end

   // prefix sums of effective weights
   always_ff @(posedge clock) begin
      if (cmd.cum_we) begin
         cum_mem_ff[cmd.cum_waddr] <= cmd.cum_wdata;
      end
      cum_rd_ff <= cum_mem_ff[cmd.cum_raddr];
   end

   assign base_rdata = base_rd_ff;
   assign cum_rdata  = cum_rd_ff;

endmodule

// ===== design/wss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the weighted source selector, bound to the top level.
// ----------------------------------------------------------------------------
module wss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [wss_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import wss_pkg::*;

   // nothing leaves or enters while the tables are being cleared
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("response or request ready right after reset");

   // one request in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   // a choice never comes with an error or the all-done flag
   a_choice_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[RSP_VALID_BIT]) |->
         !rsp_tdata[RSP_ERROR_BIT] && !rsp_tdata[RSP_DONE_BIT])
      else $error("choice with error or all-done flag");

   // no choice means source zero
   a_no_choice_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[RSP_VALID_BIT]) |-> (rsp_tdata[IDX_BITS-1:0] == '0))
      else $error("source index without a choice");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind weighted_source_selector wss_checker u_wss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_weighted_source_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_source_selector
// Self-checking bench for the weighted source selector. A queue of requests
// feeds a clocked stream driver. A clocked monitor predicts every accepted
// request against a local copy of the weight tables and done flags, and checks
// each response against the oldest prediction. The run starts with directed
// corner cases and then goes through random phases under several source
// counts, repeat settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_weighted_source_selector;
   import wss_pkg::*;

   // unused register index, written once; the block ignores it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = CSR_INDEX_BITS'(15);
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 90;

   typedef struct {
      req_kind_type           kind;
      logic [IDX_BITS-1:0]    idx;
      logic [WEIGHT_BITS-1:0] weight;
      logic [FRAC_BITS-1:0]   frac;
      logic                   end_kind;
   } request_type;

   typedef struct {
      logic [IDX_BITS-1:0] chosen;
      logic                valid;
      logic                done;
      logic                err;
   } choice_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_USER_BITS-1:0]  req_tuser = '0;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // stimulus and prediction bookkeeping
   request_type pending_requests[$];
   choice_type  expected_choices[$];
   logic        req_took = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;

   // local copy of the selector state and registers
   logic [CNT_BITS-1:0]    cfg_num_sources;
   logic                   cfg_repeat;
   logic [WEIGHT_BITS-1:0] sel_base [MAX_SOURCES];
   logic [CUM_BITS-1:0]    sel_cum  [MAX_SOURCES];
   logic                   sel_done [MAX_SOURCES];

   weighted_source_selector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // replace one effective weight and rebuild the prefix sums
   function automatic void set_effective_weight(input int unsigned idx,
                                                input logic [CUM_BITS-1:0] w);
      logic [CUM_BITS-1:0] eff [MAX_SOURCES];
      logic [CUM_BITS-1:0] prev;
      logic [CUM_BITS-1:0] acc;
      prev = '0;
      acc = '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
         eff[i] = sel_cum[i] - prev;
         prev = sel_cum[i];
      end
      eff[idx] = w;
      for (int i = 0; i < MAX_SOURCES; i++) begin
         acc = acc + eff[i];
         sel_cum[i] = acc;
      end
   endfunction

   function automatic logic sources_all_done(input int unsigned n);
      logic all;
      all = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (!sel_done[i]) all = 1'b0;
      end
      return all;
   endfunction

   // expected response of one request, updating the local state
   function automatic choice_type predict_selection(input request_type rq);
      choice_type          res;
      int unsigned         n;
      int unsigned         pick;
      int unsigned         steps;
      logic                found;
      logic [CUM_BITS-1:0] total;
      logic [CUM_BITS-1:0] acc;
      logic [63:0]         target;
      res = '{chosen: '0, valid: 1'b0, done: 1'b0, err: 1'b0};
      if (cfg_num_sources == 0) begin
         n = 1;
      end else if (cfg_num_sources > MAX_SOURCES) begin
         n = MAX_SOURCES;
      end else begin
         n = cfg_num_sources;
      end
      case (rq.kind)
         REQ_LOAD, REQ_END: begin
            if (rq.idx >= n) begin
               res.err = 1'b1;
            end else if (rq.kind == REQ_LOAD) begin
               sel_base[rq.idx] = rq.weight;
               set_effective_weight(rq.idx, CUM_BITS'(rq.weight));
            end else begin
               sel_done[rq.idx] = 1'b1;
               // a drained source loses its weight when repeats are off
               if (!rq.end_kind && !cfg_repeat) set_effective_weight(rq.idx, '0);
            end
         end
         REQ_DRAW: begin
            total = sel_cum[n - 1];
            if (!sources_all_done(n)) begin
               if (total == 0) begin
                  res.err = 1'b1;
               end else begin
                  // first entry with cum * 2^frac_bits strictly above frac * total
                  target = 64'(rq.frac) * 64'(total);
                  pick = n - 1;
                  found = 1'b0;
                  for (int i = 0; i < n; i++) begin
                     if (!found && ((64'(sel_cum[i]) << FRAC_BITS) > target)) begin
                        pick = i;
                        found = 1'b1;
                     end
                  end
                  // skip done sources, wrapping past the last one in use
                  if (!cfg_repeat) begin
                     steps = 0;
                     while (steps < n && sel_done[pick]) begin
                        pick = (pick + 1 < n) ? pick + 1 : 0;
                        steps++;
                     end
                  end
                  res.chosen = IDX_BITS'(pick);
                  res.valid = 1'b1;
               end
            end
         end
         default: begin
            acc = '0;
            for (int i = 0; i < MAX_SOURCES; i++) begin
               sel_done[i] = 1'b0;
               acc = acc + CUM_BITS'(sel_base[i]);
               sel_cum[i] = acc;
            end
         end
      endcase
      res.done = sources_all_done(n);
      return res;
   endfunction

   // request driver: holds an offered request until taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (req_took) void'(pending_requests.pop_front());
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_requests[0].kind;
            req_tdata  <= REQ_DATA_BITS'({pending_requests[0].end_kind,
                                          pending_requests[0].frac,
                                          pending_requests[0].weight,
                                          pending_requests[0].idx});
         end else begin
            req_tvalid <= 1'b0;
            req_tuser  <= REQ_USER_BITS'($urandom());
            req_tdata  <= REQ_DATA_BITS'({$urandom(), $urandom()});
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // response checker and request predictor
   always @(posedge clock) begin
      choice_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_choices.size() == 0) begin
               $error("response with no request outstanding: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_choices.pop_front();
               if (rsp_tdata[IDX_BITS-1:0] !== want.chosen) begin
                  $error("chosen_source mismatch: expected %0d, actual %0d",
                         want.chosen, rsp_tdata[IDX_BITS-1:0]);
                  error_count++;
               end
               if (rsp_tdata[RSP_VALID_BIT] !== want.valid) begin
                  $error("choice_valid mismatch: expected %0d, actual %0d",
                         want.valid, rsp_tdata[RSP_VALID_BIT]);
                  error_count++;
               end
               if (rsp_tdata[RSP_DONE_BIT] !== want.done) begin
                  $error("all_sources_done mismatch: expected %0d, actual %0d",
                         want.done, rsp_tdata[RSP_DONE_BIT]);
                  error_count++;
               end
               if (rsp_tdata[RSP_ERROR_BIT] !== want.err) begin
                  $error("request_error mismatch: expected %0d, actual %0d",
                         want.err, rsp_tdata[RSP_ERROR_BIT]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_choices = {expected_choices, predict_selection(pending_requests[0])};
         end
      end
   end

   task automatic add_request(input req_kind_type kind, input int unsigned idx,
                              input int unsigned weight, input int unsigned frac,
                              input logic end_kind);
      request_type rq;
      rq.kind     = kind;
      rq.idx      = IDX_BITS'(idx);
      rq.weight   = WEIGHT_BITS'(weight);
      rq.frac     = FRAC_BITS'(frac);
      rq.end_kind = end_kind;
      pending_requests = {pending_requests, rq};
   endtask

   // mostly loads and draws on sources in use, some end reports and restarts
   task automatic add_random_request(input int unsigned n);
      req_kind_type kind;
      int unsigned  sel;
      int unsigned  idx;
      int unsigned  weight;
      int unsigned  frac;
      sel = $urandom_range(99);
      if (sel < 30) kind = REQ_LOAD;
      else if (sel < 75) kind = REQ_DRAW;
      else if (sel < 93) kind = REQ_END;
      else kind = REQ_RESTART;
      idx = ($urandom_range(99) < 85) ? $urandom_range(n - 1) : $urandom_range(15);
      sel = $urandom_range(99);
      if (sel < 10) weight = 0;
      else if (sel < 20) weight = 16'hFFFF;
      else if (sel < 50) weight = $urandom_range(15);
      else weight = $urandom_range(16'hFFFF);
      sel = $urandom_range(99);
      if (sel < 10) frac = 0;
      else if (sel < 20) frac = 24'hFFFFFF;
      else frac = $urandom_range(24'hFFFFFF);
      add_request(kind, idx, weight, frac, 1'($urandom()));
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_NUM_SOURCES) cfg_num_sources = data;
      else if (index == CSR_REPEAT_MODE) cfg_repeat = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every request to be taken and answered, then let the block settle
   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_choices.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // main sequence
   initial begin
      logic [CNT_BITS-1:0] phase_count [8];
      logic                phase_repeat [8];
      int unsigned         n_eff;
      phase_count  = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd17, 5'd1};
      phase_repeat = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      cfg_num_sources = CNT_BITS'(1);
      cfg_repeat = 1'b1;
      for (int i = 0; i < MAX_SOURCES; i++) begin
         sel_base[i] = '0;
         sel_cum[i]  = '0;
         sel_done[i] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one source, repeats on
      add_request(REQ_DRAW, 0, 0, 24'h123456, 1'b0);
      add_request(REQ_LOAD, 0, 16'hFFFF, 0, 1'b0);
      add_request(REQ_LOAD, 15, 16'h00FF, 0, 1'b0);
      add_request(REQ_END, 5, 0, 0, 1'b1);
      add_request(REQ_DRAW, 0, 0, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      add_request(REQ_END, 0, 0, 0, 1'b1);
      add_request(REQ_DRAW, 0, 0, 24'h800000, 1'b0);
      add_request(REQ_RESTART, 0, 0, 0, 1'b0);
      wait_idle();

      // all sixteen sources, drained sources removed
      write_csr(CSR_NUM_SOURCES, CSR_DATA_BITS'(16));
      write_csr(CSR_REPEAT_MODE, CSR_DATA_BITS'(0));
      add_request(REQ_LOAD, 0, 0, 0, 1'b0);
      add_request(REQ_LOAD, 1, 1, 0, 1'b0);
      add_request(REQ_LOAD, 7, 16'h8000, 0, 1'b0);
      add_request(REQ_LOAD, 15, 16'hFFFF, 0, 1'b0);
      add_request(REQ_LOAD, 3, 16'h1234, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      add_request(REQ_END, 15, 0, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      add_request(REQ_END, 7, 0, 0, 1'b1);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      // a done last source sends the skip around to source zero
      add_request(REQ_LOAD, 15, 16'hFFFF, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      add_request(REQ_RESTART, 0, 0, 0, 1'b0);
      add_request(REQ_DRAW, 0, 0, 24'hFFFFFF, 1'b0);
      wait_idle();

      write_csr(CSR_SPARE_INDEX, CSR_DATA_BITS'(3));

      // random phases over source counts, repeat settings and idling
      for (int p = 0; p < 8; p++) begin
         write_csr(CSR_NUM_SOURCES, phase_count[p]);
         write_csr(CSR_REPEAT_MODE, CSR_DATA_BITS'(phase_repeat[p]));
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 53;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 53;
            end
            default: begin
               send_idle_pct = 26;
               recv_stall_pct = 26;
            end
         endcase
         if (phase_count[p] == 0) n_eff = 1;
         else if (phase_count[p] > MAX_SOURCES) n_eff = MAX_SOURCES;
         else n_eff = phase_count[p];
         for (int k = 0; k < PHASE_ITEMS; k++) add_random_request(n_eff);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
